// File: hw/rtl/fik_pkg.sv
// Package for the three-segment inverse-kinematics solver core.
// Holds coordinate widths, register indexes, status codes and shared structs.
// Depends on nothing.
package fik_pkg;

    localparam int CoordWidth  = 32;
    localparam int LenWidth    = 31;
    localparam int DiffWidth   = CoordWidth + 1;
    localparam int SqWidth     = 2 * DiffWidth + 2;
    localparam int RootWidth   = SqWidth / 2;
    localparam int ProdWidth   = DiffWidth + LenWidth;
    localparam int CfgIdxWidth = 3;

    localparam logic [CfgIdxWidth-1:0] REG_LENGTH_FIRST  = 3'd0;
    localparam logic [CfgIdxWidth-1:0] REG_LENGTH_SECOND = 3'd1;
    localparam logic [CfgIdxWidth-1:0] REG_LENGTH_THIRD  = 3'd2;
    localparam logic [CfgIdxWidth-1:0] REG_TOLERANCE     = 3'd3;
    localparam logic [CfgIdxWidth-1:0] REG_PASS_LIMIT    = 3'd4;

    localparam logic [1:0] STATUS_CONVERGED   = 2'd0;
    localparam logic [1:0] STATUS_LIMIT       = 2'd1;
    localparam logic [1:0] STATUS_UNREACHABLE = 2'd2;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_SOLVE = 1'b1;

    typedef logic signed [CoordWidth-1:0] coord_t;

    // Request from the sequencer to the shared root and divide unit.
    typedef struct packed {
        logic              start_sqrt;
        logic              start_div;
        logic [SqWidth-1:0] operand;
        logic [RootWidth-1:0] divisor;
    } fik_req_t;

    typedef struct packed {
        logic                 done;
        logic [RootWidth-1:0] result;
    } fik_rsp_t;

    function automatic coord_t sat_coord(input logic signed [CoordWidth+1:0] v);
        logic signed [CoordWidth+1:0] hi;
        logic signed [CoordWidth+1:0] lo;
        hi = (CoordWidth+2)'({1'b0, {(CoordWidth-1){1'b1}}});
        lo = -hi - (CoordWidth+2)'(1);
        if (v > hi)
            return hi[CoordWidth-1:0];
        else if (v < lo)
            return lo[CoordWidth-1:0];
        return v[CoordWidth-1:0];
    endfunction

endpackage

// File: hw/rtl/fabrik_three_segment_ik_solver_core.sv
// Top level of the three-segment inverse-kinematics solver core.
// Depends on fik_pkg and fik_unit.
//
// Usage: words on the s_axis channel either load a stored joint (op 0) or
// ask for a solve toward a goal (op 1). A load is taken only while idle and
// gives no output. A solve gives four words on m_axis, joints 0 to 3 in order, with
// tlast on the fourth; tuser carries the status (0 converged, 1 pass limit,
// 2 unreachable). The configuration port writes segment lengths, tolerance
// and pass limit; write it only while the core is idle.
// Work: one solve runs up to pass_limit + 1 passes. Each pass has one
// distance check and six joint placements; a placement needs one square root
// and three divisions (none when the root is zero) on the single shared
// root/divide unit, plus a multiply and an update per coordinate. The pass
// limit defaults to 100 and is at most 255. The core takes no new word
// until the pose is fully sent.
// Reset returns the stored pose to zero and the registers to their defaults.
// A stalled receiver simply holds the output word until tready returns.
module fabrik_three_segment_ik_solver_core
    import fik_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [103:0]           s_axis_tdata,  // joint[1:0], x, y, z (2..97), zero pad
    input  logic                   s_axis_tuser,  // op
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [103:0]           m_axis_tdata,  // joint_index[1:0], pos_x, pos_y, pos_z, pad
    output logic [1:0]             m_axis_tuser,  // status
    output logic                   m_axis_tlast,
    input  logic                   cfg_we,
    input  logic [CfgIdxWidth-1:0] cfg_index,
    input  logic [LenWidth-1:0]    cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_REACH, ST_CHECK, ST_SETUP, ST_SQ, ST_SQRT, ST_MUL,
        ST_DIV, ST_APPLY, ST_NEXT, ST_OUT
    } state_t;

    state_t               state_reg, state_next;
    logic [LenWidth-1:0]  len1_reg, len2_reg, len3_reg, tol_reg;
    logic [7:0]           limit_reg;
    coord_t               stored_reg [4][3];
    coord_t               work_reg [4][3];
    coord_t               goal_reg [3];
    logic [7:0]           pass_reg, pass_next;
    logic [2:0]           step_reg, step_next;   // placement 0..5
    logic [1:0]           comp_reg, comp_next;   // coordinate 0..2
    logic [1:0]           outk_reg, outk_next;
    logic [1:0]           status_reg, status_next;
    logic [SqWidth-1:0]   acc_reg, acc_next;
    logic [RootWidth-1:0] root_reg;
    logic [ProdWidth-1:0] prod;
    logic signed [DiffWidth-1:0] diff_reg [3];
    fik_req_t             req;
    fik_rsp_t             rsp;

    fik_unit u_unit (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    // Anchor, moved joint and length of each placement step.
    logic [1:0]          anc_idx, tgt_idx;
    logic [LenWidth-1:0] step_len;
    always_comb
    begin
        unique case (step_reg)
            3'd0: begin anc_idx = 2'd3; tgt_idx = 2'd2; step_len = len3_reg; end
            3'd1: begin anc_idx = 2'd2; tgt_idx = 2'd1; step_len = len2_reg; end
            3'd2: begin anc_idx = 2'd1; tgt_idx = 2'd0; step_len = len1_reg; end
            3'd3: begin anc_idx = 2'd0; tgt_idx = 2'd1; step_len = len1_reg; end
            3'd4: begin anc_idx = 2'd1; tgt_idx = 2'd2; step_len = len2_reg; end
            default: begin anc_idx = 2'd2; tgt_idx = 2'd3; step_len = len3_reg; end
        endcase
    end

    logic in_fire, out_fire;
    logic in_op;
    logic [1:0] in_joint;
    coord_t in_c [3];
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign in_op    = s_axis_tuser;
    assign in_joint = s_axis_tdata[1:0];
    assign in_c[0]  = s_axis_tdata[33:2];
    assign in_c[1]  = s_axis_tdata[65:34];
    assign in_c[2]  = s_axis_tdata[97:66];

    // Difference of the component under work, one per cycle.
    logic signed [DiffWidth-1:0] cur_diff;
    logic [DiffWidth-1:0]        cur_mag;
    logic [LenWidth+1:0]         reach_sum;
    logic [SqWidth-1:0]          limit_sq;
    coord_t                      ref_a, ref_b;
    always_comb
    begin
        ref_a = work_reg[anc_idx][comp_reg];
        ref_b = work_reg[tgt_idx][comp_reg];
        if (state_reg == ST_REACH)
        begin
            ref_a = stored_reg[0][comp_reg];
            ref_b = goal_reg[comp_reg];
        end
        else if (state_reg == ST_CHECK)
        begin
            ref_a = work_reg[3][comp_reg];
            ref_b = goal_reg[comp_reg];
        end
        cur_diff = DiffWidth'(ref_b) - DiffWidth'(ref_a);
        cur_mag  = cur_diff[DiffWidth-1] ? DiffWidth'(-cur_diff) : DiffWidth'(cur_diff);
        reach_sum = (LenWidth+2)'(len1_reg) + (LenWidth+2)'(len2_reg)
                  + (LenWidth+2)'(len3_reg);
        limit_sq = (state_reg == ST_REACH) ? SqWidth'(reach_sum * reach_sum)
                                           : SqWidth'(tol_reg * tol_reg);
    end

    logic [SqWidth-1:0] sq_term;
    assign sq_term = SqWidth'(cur_mag * cur_mag);

    logic [DiffWidth-1:0] dmag;
    assign dmag = diff_reg[comp_reg][DiffWidth-1] ? DiffWidth'(-diff_reg[comp_reg])
                                                   : DiffWidth'(diff_reg[comp_reg]);

    // Magnitude times segment length, handed straight to the divider.
    assign prod = dmag * step_len;

    logic signed [CoordWidth+1:0] new_val;
    always_comb
    begin
        logic signed [CoordWidth+1:0] off;
        off = '0;
        if (root_reg != '0)
            off = diff_reg[comp_reg][DiffWidth-1]
                ? -$signed((CoordWidth+2)'(rsp.result)) : $signed((CoordWidth+2)'(rsp.result));
        new_val = (CoordWidth+2)'(work_reg[anc_idx][comp_reg]) + off;
    end

    always_comb
    begin
        state_next  = state_reg;
        pass_next   = pass_reg;
        step_next   = step_reg;
        comp_next   = comp_reg;
        outk_next   = outk_reg;
        status_next = status_reg;
        acc_next    = acc_reg;
        req         = '0;
        unique case (state_reg)
            ST_IDLE:
                if (in_fire && in_op == OP_SOLVE)
                begin
                    state_next = ST_REACH;
                    comp_next  = 2'd0;
                    acc_next   = '0;
                end
            ST_REACH, ST_CHECK:
            begin
                acc_next = acc_reg + sq_term;
                comp_next = comp_reg + 2'd1;
                if (comp_reg == 2'd2)
                begin
                    comp_next = 2'd0;
                    if (state_reg == ST_REACH)
                    begin
                        if (acc_next > limit_sq)
                        begin
                            status_next = STATUS_UNREACHABLE;
                            state_next  = ST_OUT;
                            outk_next   = 2'd0;
                        end
                        else
                        begin
                            pass_next  = '0;
                            acc_next   = '0;
                            state_next = ST_CHECK;
                        end
                    end
                    else if (acc_next < limit_sq)
                    begin
                        status_next = STATUS_CONVERGED;
                        state_next  = ST_OUT;
                        outk_next   = 2'd0;
                    end
                    else
                    begin
                        step_next  = 3'd0;
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_SETUP:
            begin
                acc_next   = '0;
                comp_next  = 2'd0;
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                acc_next  = acc_reg + sq_term;
                comp_next = comp_reg + 2'd1;
                if (comp_reg == 2'd2)
                begin
                    comp_next  = 2'd0;
                    state_next = ST_SQRT;
                    req.start_sqrt = 1'b1;
                    req.operand    = acc_next;
                end
            end
            ST_SQRT:
                if (rsp.done)
                    state_next = ST_MUL;
            ST_MUL:
            begin
                state_next    = ST_DIV;
                req.start_div = (root_reg != '0);
                req.operand   = SqWidth'(prod);
                req.divisor   = root_reg;
                if (root_reg == '0)
                    state_next = ST_APPLY;
            end
            ST_DIV:
                if (rsp.done)
                    state_next = ST_APPLY;
            ST_APPLY:
            begin
                comp_next  = comp_reg + 2'd1;
                state_next = ST_MUL;
                if (comp_reg == 2'd2)
                begin
                    comp_next  = 2'd0;
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                step_next  = step_reg + 3'd1;
                state_next = ST_SETUP;
                if (step_reg == 3'd5)
                begin
                    if (pass_reg >= limit_reg)
                    begin
                        status_next = STATUS_LIMIT;
                        state_next  = ST_OUT;
                        outk_next   = 2'd0;
                    end
                    else
                    begin
                        pass_next  = pass_reg + 8'd1;
                        acc_next   = '0;
                        comp_next  = 2'd0;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_OUT:
                if (out_fire)
                begin
                    outk_next = outk_reg + 2'd1;
                    if (outk_reg == 2'd3)
                        state_next = ST_IDLE;
                end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pass_reg   <= '0;
            step_reg   <= '0;
            comp_reg   <= '0;
            outk_reg   <= '0;
            status_reg <= STATUS_CONVERGED;
            len1_reg   <= LenWidth'(65536);
            len2_reg   <= LenWidth'(65536);
            len3_reg   <= LenWidth'(65536);
            tol_reg    <= LenWidth'(328);
            limit_reg  <= 8'd100;
            for (int j = 0; j < 4; j++)
                for (int c = 0; c < 3; c++)
                    stored_reg[j][c] <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            pass_reg   <= pass_next;
            step_reg   <= step_next;
            comp_reg   <= comp_next;
            outk_reg   <= outk_next;
            status_reg <= status_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_LENGTH_FIRST:  len1_reg  <= cfg_data;
                    REG_LENGTH_SECOND: len2_reg  <= cfg_data;
                    REG_LENGTH_THIRD:  len3_reg  <= cfg_data;
                    REG_TOLERANCE:     tol_reg   <= cfg_data;
                    REG_PASS_LIMIT:    limit_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (in_fire && in_op == OP_LOAD)
                for (int c = 0; c < 3; c++)
                    stored_reg[in_joint][c] <= in_c[c];
        end
    end

    // Datapath registers; no reset needed.
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (in_fire && in_op == OP_SOLVE)
        begin
            for (int c = 0; c < 3; c++)
                goal_reg[c] <= in_c[c];
            work_reg <= stored_reg;
        end
        if (state_reg == ST_CHECK && state_next == ST_SETUP)
            for (int c = 0; c < 3; c++)
                work_reg[3][c] <= goal_reg[c];
        if (state_reg == ST_NEXT && step_reg == 3'd2)
            work_reg[0] <= stored_reg[0];
        if (state_reg == ST_SQ)
            diff_reg[comp_reg] <= cur_diff;
        if (state_reg == ST_SQRT && rsp.done)
            root_reg <= rsp.result;
        if (state_reg == ST_APPLY)
            work_reg[tgt_idx][comp_reg] <= sat_coord(new_val);
    end

    logic [1:0] out_status;
    assign out_status    = status_reg;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = {6'd0, work_reg[outk_reg][2], work_reg[outk_reg][1],
                            work_reg[outk_reg][0], outk_reg};
    assign m_axis_tuser  = out_status;
    assign m_axis_tlast  = (outk_reg == 2'd3);

    a_no_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("accepting while sending");
    a_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE && state_reg != ST_OUT && state_reg != ST_REACH
        |-> pass_reg <= limit_reg || limit_reg == 8'd0) else $error("pass overrun");
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        req.start_div |-> root_reg != '0) else $error("divide by zero");

endmodule

// File: hw/rtl/fik_unit.sv
// Shared bit-serial square root and restoring divider, one bit per cycle.
// Depends on fik_pkg.
module fik_unit
    import fik_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  fik_req_t req,
    output fik_rsp_t rsp
);

    localparam int CntWidth = $clog2(SqWidth + 1);

    logic                 busy_reg, busy_next;
    logic                 is_div_reg, is_div_next;
    logic [CntWidth-1:0]  cnt_reg, cnt_next;
    logic [SqWidth-1:0]   num_reg, num_next;
    logic [RootWidth-1:0] den_reg, den_next;
    logic [SqWidth:0]     rem_reg, rem_next;
    logic [RootWidth-1:0] quo_reg, quo_next;
    logic                 done_reg, done_next;

    logic [SqWidth+1:0]   trial;
    logic [SqWidth:0]     shifted;

    always_comb
    begin
        busy_next   = busy_reg;
        is_div_next = is_div_reg;
        cnt_next    = cnt_reg;
        num_next    = num_reg;
        den_next    = den_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        done_next   = 1'b0;
        shifted     = '0;
        trial       = '0;
        if (req.start_sqrt || req.start_div)
        begin
            busy_next   = 1'b1;
            is_div_next = req.start_div;
            num_next    = req.operand;
            den_next    = req.divisor;
            rem_next    = '0;
            quo_next    = '0;
            cnt_next    = req.start_div ? CntWidth'(SqWidth) : CntWidth'(RootWidth);
        end
        else if (busy_reg)
        begin
            if (is_div_reg)
            begin
                // Restoring division, one numerator bit a cycle.
                shifted  = {rem_reg[SqWidth-1:0], num_reg[SqWidth-1]};
                num_next = {num_reg[SqWidth-2:0], 1'b0};
                trial    = {1'b0, shifted} - (SqWidth+2)'(den_reg);
                if (!trial[SqWidth+1])
                begin
                    rem_next = trial[SqWidth:0];
                    quo_next = {quo_reg[RootWidth-2:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted;
                    quo_next = {quo_reg[RootWidth-2:0], 1'b0};
                end
            end
            else
            begin
                // Digit-by-digit root, two radicand bits a cycle.
                shifted  = {rem_reg[SqWidth-2:0], num_reg[SqWidth-1:SqWidth-2]};
                num_next = {num_reg[SqWidth-3:0], 2'b00};
                trial    = {1'b0, shifted}
                         - (SqWidth+2)'({quo_reg, 2'b01});
                if (!trial[SqWidth+1])
                begin
                    rem_next = trial[SqWidth:0];
                    quo_next = {quo_reg[RootWidth-2:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted;
                    quo_next = {quo_reg[RootWidth-2:0], 1'b0};
                end
            end
            cnt_next = cnt_reg - CntWidth'(1);
            if (cnt_reg == CntWidth'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_div_reg <= is_div_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = quo_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> $past(busy_reg)) else $error("done without work");
    a_no_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> !busy_reg) else $error("done while busy");
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> cnt_reg == '0) else $error("count left over");

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the three-segment inverse-kinematics solver core.
// Depends on fik_pkg and fabrik_three_segment_ik_solver_core; predicts each pose
// in place and compares every output word against it.
`timescale 1ns / 1ps

module tb_top;
    import fik_pkg::*;

    localparam longint CycleLimit = 20_000_000;

    // Fields of one output word as the predictor works them out.
    typedef struct {
        logic [1:0] joint_index;
        coord_t     pos_x;
        coord_t     pos_y;
        coord_t     pos_z;
        logic [1:0] status;
        logic       last;
    } pose_word_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [103:0]           s_axis_tdata;   // joint[1:0], x, y, z, zero pad
    logic                   s_axis_tuser;   // op
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [103:0]           m_axis_tdata;   // joint_index[1:0], pos_x, pos_y, pos_z, pad
    logic [1:0]             m_axis_tuser;   // status
    logic                   m_axis_tlast;
    logic                   cfg_we;
    logic [CfgIdxWidth-1:0] cfg_index;
    logic [LenWidth-1:0]    cfg_data;

    // Predictor state: the stored pose, the working pose and the registers.
    longint      stored_pose [4][3];
    longint      working_pose[4][3];
    logic [63:0] seg_length[3];
    logic [63:0] tol_dist;
    int          passes_max;

    pose_word_t  pending_pose_q[$];
    int          mismatches;
    longint      cycles;
    bit          quiet;         // no idling on either side when set
    int          hold_off;      // receiver stall requested by a test
    bit          stalling;      // set while the long stall runs

    fabrik_three_segment_ik_solver_core uut (.*);

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Watchdog: the run must end well inside the limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("FAIL fabrik_three_segment_ik_solver_core");
            $finish;
        end
    end

    // Long receiver stall: counts off the cycles that a test asks for.
    initial
    begin
        stalling = 1'b0;
        forever
        begin
            wait (hold_off > 0);
            stalling = 1'b1;
            repeat (hold_off) @(posedge clk);
            hold_off = 0;
            stalling = 1'b0;
        end
    end

    //------------------------------------------------------------------
    // Predictor
    //------------------------------------------------------------------

    function automatic logic [127:0] dist_sq(longint a[3], longint b[3]);
        logic [127:0] s;
        longint       d;
        logic [63:0]  m;
        s = 0;
        for (int i = 0; i < 3; i++)
        begin
            d = b[i] - a[i];
            m = d < 0 ? -d : d;
            s += {64'd0, m} * {64'd0, m};
        end
        return s;
    endfunction

    function automatic logic [63:0] floor_root(logic [127:0] s);
        logic [63:0] r;
        logic [63:0] t;
        r = 0;
        for (int b = 63; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if ({64'd0, t} * {64'd0, t} <= s)
                r = t;
        end
        return r;
    endfunction

    function automatic longint clamp_coord(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Moves working joint t to distance seg from working joint a, along a to t.
    // A zero-length direction leaves the joint on its anchor.
    function automatic void place_joint(int a, int t, logic [63:0] seg);
        logic [63:0]  len;
        logic [127:0] c;
        longint       d;
        longint       off;
        logic [63:0]  m;
        len = floor_root(dist_sq(working_pose[a], working_pose[t]));
        for (int i = 0; i < 3; i++)
        begin
            d = working_pose[t][i] - working_pose[a][i];
            m = d < 0 ? -d : d;
            off = 0;
            if (len != 0)
            begin
                c = ({64'd0, m} * {64'd0, seg}) / {64'd0, len};
                off = d < 0 ? -longint'(c[63:0]) : longint'(c[63:0]);
            end
            working_pose[t][i] = clamp_coord(working_pose[a][i] + off);
        end
    endfunction

    // Solves toward the goal and queues the four words of the resulting pose.
    function automatic void predict_pose(longint goal[3]);
        logic [63:0]  reach_sum;
        logic [1:0]   st;
        pose_word_t   w;
        reach_sum = seg_length[0] + seg_length[1] + seg_length[2];
        working_pose = stored_pose;
        if (dist_sq(stored_pose[0], goal) > {64'd0, reach_sum} * {64'd0, reach_sum})
            st = STATUS_UNREACHABLE;
        else
        begin
            st = STATUS_LIMIT;
            for (int pass = 0; ; pass++)
            begin
                if (dist_sq(working_pose[3], goal) < {64'd0, tol_dist} * {64'd0, tol_dist})
                begin
                    st = STATUS_CONVERGED;
                    break;
                end
                // Backward sweep from the goal, then forward from the mount.
                working_pose[3] = goal;
                place_joint(3, 2, seg_length[2]);
                place_joint(2, 1, seg_length[1]);
                place_joint(1, 0, seg_length[0]);
                working_pose[0] = stored_pose[0];
                place_joint(0, 1, seg_length[0]);
                place_joint(1, 2, seg_length[1]);
                place_joint(2, 3, seg_length[2]);
                if (pass >= passes_max)
                    break;
            end
        end
        for (int k = 0; k < 4; k++)
        begin
            w.joint_index = k[1:0];
            w.pos_x  = working_pose[k][0][31:0];
            w.pos_y  = working_pose[k][1][31:0];
            w.pos_z  = working_pose[k][2][31:0];
            w.status = st;
            w.last   = (k == 3);
            pending_pose_q.push_back(w);
        end
    endfunction

    //------------------------------------------------------------------
    // Stimulus helpers
    //------------------------------------------------------------------

    // Sends one word and, once it is accepted, updates the predictor.
    // Returns at the accepting edge without touching tvalid.
    task automatic send_word(logic op, logic [1:0] joint, coord_t x, coord_t y, coord_t z);
        bit     accepted;
        longint pt[3];
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {6'd0, z, y, x, joint};
        do
        begin
            @(negedge clk);
            accepted = s_axis_tready;
            @(posedge clk);
        end
        while (!accepted);
        pt[0] = x;
        pt[1] = y;
        pt[2] = z;
        if (op == OP_LOAD)
            stored_pose[joint] = pt;
        else
            predict_pose(pt);
    endtask

    // Waits until every pose has arrived and the core has had time to settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_pose_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Writes one register; called only after drain(). The write enable stays
    // high so that writes can follow back to back; the caller drops it.
    task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [LenWidth-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            REG_LENGTH_FIRST:  seg_length[0] = 64'(value);
            REG_LENGTH_SECOND: seg_length[1] = 64'(value);
            REG_LENGTH_THIRD:  seg_length[2] = 64'(value);
            REG_TOLERANCE:     tol_dist      = 64'(value);
            REG_PASS_LIMIT:    passes_max    = value[7:0];
            default: ;
        endcase
    endtask

    task automatic set_arm(logic [30:0] l1, logic [30:0] l2, logic [30:0] l3,
                           logic [30:0] tol, logic [7:0] limit);
        drain();
        write_reg(REG_LENGTH_FIRST, l1);
        write_reg(REG_LENGTH_SECOND, l2);
        write_reg(REG_LENGTH_THIRD, l3);
        write_reg(REG_TOLERANCE, tol);
        write_reg(REG_PASS_LIMIT, {23'd0, limit});
        cfg_we <= 1'b0;
    endtask

    // Mostly coordinates within a few units of the origin; now and then any
    // 32-bit value, so that every bit of every field moves.
    function automatic coord_t rand_coord();
        if ($urandom_range(0, 5) == 0)
            return $urandom;
        return $urandom_range(0, 32'h80000) - 32'h40000;
    endfunction

    task automatic load_pose(coord_t c[4][3]);
        for (int j = 0; j < 4; j++)
            send_word(OP_LOAD, j[1:0], c[j][0], c[j][1], c[j][2]);
    endtask

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------

    // Straight after reset: all joints at the origin, unit segments.
    task automatic test_reset_defaults();
        send_word(OP_SOLVE, 2'd0, 0, 0, 0);                     // already converged
        send_word(OP_SOLVE, 2'd3, 32'sh40000, 0, 0);            // four units away: unreachable
        send_word(OP_SOLVE, 2'd0, 32'sh30000, 0, 0);            // exactly at full reach
    endtask

    // A straight arm of unit segments and a reachable goal, with a pass limit
    // of zero, which still runs one pass, and then a limit of one.
    task automatic test_pass_limits();
        coord_t arm[4][3];
        for (int j = 0; j < 4; j++)
        begin
            arm[j][0] = j * 32'sh10000;
            arm[j][1] = 0;
            arm[j][2] = 0;
        end
        set_arm(31'h10000, 31'h10000, 31'h10000, 31'd328, 8'd0);
        load_pose(arm);
        send_word(OP_SOLVE, 2'd1, 32'sh18000, 32'sh18000, 32'sh8000);
        set_arm(31'h10000, 31'h10000, 31'h10000, 31'd0, 8'd1);
        send_word(OP_SOLVE, 2'd2, -32'sh10000, 32'sh20000, -32'sh8000);
        // The largest limit, with a goal that is met before the first pass.
        set_arm(31'h10000, 31'h10000, 31'h10000, 31'h7fffffff, 8'd255);
        send_word(OP_SOLVE, 2'd0, 32'sh12345, -32'sh5432, 32'sh777);
    endtask

    // Every joint on the mount and the goal on it too, with zero tolerance:
    // each placement has a zero-length direction.
    task automatic test_zero_direction();
        coord_t pile[4][3];
        for (int j = 0; j < 4; j++)
        begin
            pile[j][0] = 32'sh5000;
            pile[j][1] = -32'sh3000;
            pile[j][2] = 32'sh100;
        end
        set_arm(31'h10000, 31'h20000, 31'h8000, 31'd0, 8'd2);
        load_pose(pile);
        send_word(OP_SOLVE, 2'd3, 32'sh5000, -32'sh3000, 32'sh100);
    endtask

    // Coordinates at both ends of their range and the longest segments, so
    // that new joints land beyond the range and are saturated.
    task automatic test_extremes();
        coord_t far[4][3];
        far[0] = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
        far[1] = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000};
        far[2] = '{32'sh7fffffff, 32'sh7fffffff, 32'sh80000000};
        far[3] = '{32'sh80000000, 32'sh80000000, 32'sh7fffffff};
        set_arm(31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'd0, 8'd1);
        load_pose(far);
        send_word(OP_SOLVE, 2'd0, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
        send_word(OP_SOLVE, 2'd0, 32'sh7fffffff, 32'sh80000000, 32'sh80000000);
        // Zero-length segments: every joint collapses onto the mount.
        set_arm(31'd0, 31'd0, 31'd0, 31'd0, 8'd1);
        send_word(OP_SOLVE, 2'd0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    endtask

    // The receiver stalls for a long stretch while solves keep coming, so the
    // core has to hold off its input until each pose is sent.
    task automatic test_backpressure();
        set_arm(31'h10000, 31'h10000, 31'h10000, 31'd328, 8'd1);
        hold_off = 3000;
        for (int n = 0; n < 4; n++)
            send_word(OP_SOLVE, 2'd0, 32'sh100000, -32'sh100000, n * 32'sh1000);
    endtask

    // Random arms and goals in mostly well-formed load-then-solve sequences,
    // with the registers changed between phases.
    task automatic test_random(int items);
        coord_t arm[4][3];
        int     sent;
        int     groups;
        sent   = 0;
        groups = 0;
        while (sent < items)
        begin
            if (groups % 8 == 0)
                set_arm(31'($urandom_range(31'h4000, 31'h30000)),
                        31'($urandom_range(31'h4000, 31'h30000)),
                        31'($urandom_range(31'h4000, 31'h30000)),
                        31'($urandom_range(0, 31'h2000)),
                        8'($urandom_range(1, 3)));
            groups++;
            if (items - sent < 25)
                quiet = 1'b1;
            if ($urandom_range(0, 1) == 0)
            begin
                for (int j = 0; j < 4; j++)
                    for (int i = 0; i < 3; i++)
                        arm[j][i] = rand_coord();
                load_pose(arm);
                send_word(OP_SOLVE, 2'($urandom), rand_coord(), rand_coord(), rand_coord());
                sent += 5;
            end
            else
            begin
                send_word(1'($urandom), 2'($urandom), rand_coord(), rand_coord(),
                          rand_coord());
                sent += 1;
            end
        end
    endtask

    //------------------------------------------------------------------
    // Output checking
    //------------------------------------------------------------------

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatches++;
        $display("mismatch at cycle %0d: %s got %h expected %h", cycles, what, got, want);
    endtask

    initial
    begin
        bit           taken;
        logic [103:0] word;
        logic [1:0]   st;
        logic         lst;
        int           idle_left;
        pose_word_t   w;
        idle_left = 0;
        forever
        begin
            @(negedge clk);
            taken = m_axis_tvalid && m_axis_tready;
            word  = m_axis_tdata;
            st    = m_axis_tuser;
            lst   = m_axis_tlast;
            @(posedge clk);
            if (taken)
            begin
                if (pending_pose_q.size() == 0)
                    report_mismatch("unexpected word", word[63:0], 0);
                else
                begin
                    w = pending_pose_q.pop_front();
                    if (word[1:0] != w.joint_index)
                        report_mismatch("joint_index", word[1:0], w.joint_index);
                    if (word[33:2] != w.pos_x)
                        report_mismatch("pos_x", word[33:2], w.pos_x);
                    if (word[65:34] != w.pos_y)
                        report_mismatch("pos_y", word[65:34], w.pos_y);
                    if (word[97:66] != w.pos_z)
                        report_mismatch("pos_z", word[97:66], w.pos_z);
                    if (st != w.status)
                        report_mismatch("status", st, w.status);
                    if (lst != w.last)
                        report_mismatch("last", lst, w.last);
                end
            end
            // Decide tready for the next cycle: a requested long stall first,
            // then random bursts of idling unless the run is in its quiet part.
            if (stalling)
                m_axis_tready <= 1'b0;
            else if (idle_left > 0)
            begin
                idle_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                idle_left = $urandom_range(0, 15);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    //------------------------------------------------------------------
    // Main sequence
    //------------------------------------------------------------------

    initial
    begin
        cycles        = 0;
        mismatches    = 0;
        quiet         = 1'b0;
        hold_off      = 0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        stored_pose   = '{default: '{default: 0}};
        working_pose  = stored_pose;
        seg_length    = '{64'h10000, 64'h10000, 64'h10000};
        tol_dist      = 64'd328;
        passes_max    = 100;
        rst_n         = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_pass_limits();
        test_zero_direction();
        test_extremes();
        test_backpressure();
        test_random(150);

        drain();
        repeat (200) @(posedge clk);
        if (mismatches == 0 && pending_pose_q.size() == 0)
            $display("PASS fabrik_three_segment_ik_solver_core");
        else
            $display("FAIL fabrik_three_segment_ik_solver_core");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/fik_pkg.sv
hw/rtl/fik_unit.sv
hw/rtl/fabrik_three_segment_ik_solver_core.sv
verif/tb_top.sv
